// ===== rtl/core/ptt_pkg.sv =====
// Shared types and codes for the pending transaction table.
package ptt_pkg;

    // Action codes of an input word
    localparam logic [2:0] ACT_CREATE   = 3'd0;
    localparam logic [2:0] ACT_MATCH_K  = 3'd1;
    localparam logic [2:0] ACT_MATCH_U  = 3'd2;
    localparam logic [2:0] ACT_EXPIRE   = 3'd3;
    localparam logic [2:0] ACT_CLEANUP  = 3'd4;
    localparam logic [2:0] ACT_COMPLETE = 3'd5;
    localparam logic [2:0] ACT_CANCEL   = 3'd6;

    // Life states of a slot
    localparam logic [1:0] LIFE_PENDING   = 2'd0;
    localparam logic [1:0] LIFE_COMPLETED = 2'd1;
    localparam logic [1:0] LIFE_EXPIRED   = 2'd2;
    localparam logic [1:0] LIFE_CANCELLED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_CALL_CONTROL = 2'd0;
    localparam logic [1:0] CFG_SUPPLEMENTARY = 2'd1;

    localparam logic [3:0] CALL_CONTROL_RST = 4'd3;
    localparam logic [3:0] SUPPLEMENTARY_RST = 4'd11;

    // Payload stored per slot in the slot RAM
    typedef struct packed {
        logic [3:0] disc;
        logic [7:0] msg_type;
        logic [3:0] ident;
        logic [5:0] timer;
    } t_word;

    localparam int WORD_W = $bits(t_word);

    // Controller to datapath commands
    typedef struct packed {
        logic start;
        logic issue;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last_issue;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/ptt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/ptt_ctrl.sv =====
// Sequencer that runs one slot scan per accepted word.
module ptt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ptt_pkg::t_stat i_stat,
    output logic          o_in_stall,
    output ptt_pkg::t_cmd o_cmd
);
    import ptt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new word starts only from idle, and a finish only from done
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_SCAN))
        else $error("start did not enter the scan");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> $past(r_state == S_DRAIN) || $past(r_state == S_DONE))
        else $error("finish without a drained scan");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_DONE))
        else $error("drain did not reach done");
endmodule

// ===== rtl/core/ptt_datapath.sv =====
// Slot state, identifier index, scan checks and the result register.
module ptt_datapath #(
    parameter int SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptt_pkg::t_cmd  i_cmd,
    output ptt_pkg::t_stat o_stat,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [3:0]     i_cfg_data,
    input  logic [2:0]     i_action,
    input  logic [3:0]     i_disc,
    input  logic [7:0]     i_msg_type,
    input  logic [3:0]     i_trans_ident,
    input  logic [5:0]     i_timer_code,
    input  logic [4:0]     i_entry_id,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic           o_found,
    output logic [4:0]     o_slot_id,
    output logic [3:0]     o_hit_disc,
    output logic [7:0]     o_hit_type,
    output logic [3:0]     o_hit_ident,
    output logic [5:0]     o_hit_timer,
    output logic [4:0]     o_removed,
    output logic [4:0]     o_pending_total,
    output logic [4:0]     o_occupied_total
);
    import ptt_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = ((SW > 5) ? SW : 5) + 1;

    // Latched word and configuration
    logic [2:0] r_act;
    logic [3:0] r_disc;
    logic [7:0] r_type;
    logic [3:0] r_ident;
    logic [5:0] r_timer;
    logic [4:0] r_id;
    logic [3:0] r_cc;
    logic [3:0] r_su;

    // Slot flags and identifier index
    logic          r_used   [SLOTS];
    logic [1:0]    r_life   [SLOTS];
    logic          r_ix_vld [8];
    logic [SW-1:0] r_ix_slot[8];
    logic [CW-1:0] r_used_cnt;
    logic [CW-1:0] r_pend_cnt;

    // Scan pipeline and captures
    logic [SW-1:0] r_addr;
    logic          r_chk_vld;
    logic [SW-1:0] r_chk_slot;
    logic          r_hit;
    logic [SW-1:0] r_hit_slot;
    t_word         r_hit_word;
    logic          r_free_fnd;
    logic [SW-1:0] r_free_slot;
    logic          r_fin_fnd;
    logic [SW-1:0] r_fin_slot;
    t_word         r_fin_word;
    logic [CW-1:0] r_removed;

    // Result register
    logic          r_out_valid;
    logic          r_found;
    logic [4:0]    r_slot_id;
    t_word         r_out_word;
    logic [4:0]    r_out_removed;
    logic [4:0]    r_out_pend;
    logic [4:0]    r_out_used;

    logic [WORD_W-1:0] ram_rdata;
    t_word             rd;
    t_word             new_word;
    logic              ram_we;
    logic [SW-1:0]     pick;
    logic              create_ok;
    logic              keyed_req;
    logic              keyed_rd;
    logic              keyed_fin;
    logic              chk_used;
    logic              chk_pend;
    logic              type_matters;
    logic              id_match;
    logic              key_hit;
    logic              scan_hit;
    logic              id_hit;
    logic              hit_now;
    logic              is_create;
    logic [CW-1:0]     n_used_cnt;
    logic [CW-1:0]     n_pend_cnt;

    assign rd        = t_word'(ram_rdata);
    assign new_word  = '{disc: r_disc, msg_type: r_type, ident: r_ident, timer: r_timer};
    assign keyed_req = (r_disc == r_cc) || (r_disc == r_su);
    assign keyed_rd  = (rd.disc == r_cc) || (rd.disc == r_su);
    assign keyed_fin = (r_fin_word.disc == r_cc) || (r_fin_word.disc == r_su);
    assign chk_used  = r_used[r_chk_slot];
    assign chk_pend  = chk_used && (r_life[r_chk_slot] == LIFE_PENDING);
    assign is_create = (r_act == ACT_CREATE);

    // Per-slot hit checks on the word read back
    assign type_matters = (r_act == ACT_MATCH_K) || !keyed_req;
    assign id_match = (r_id != 5'd0) &&
        (IW'(r_id) == IW'(r_chk_slot) + IW'(1));
    assign key_hit = (r_act == ACT_MATCH_K) && keyed_req && !r_ident[3] &&
        r_ix_vld[r_ident[2:0]] && (r_ix_slot[r_ident[2:0]] == r_chk_slot) &&
        chk_pend && (rd.disc == r_disc) && (rd.ident == r_ident);
    assign scan_hit = (((r_act == ACT_MATCH_K) && !keyed_req) || (r_act == ACT_MATCH_U)) &&
        chk_pend && (rd.disc == r_disc) && (!type_matters || (rd.msg_type == r_type));
    assign id_hit = ((r_act == ACT_COMPLETE) || (r_act == ACT_CANCEL)) && chk_pend && id_match;
    assign hit_now = r_chk_vld && !r_hit && (key_hit || scan_hit || id_hit);

    // Slot chosen by create
    assign create_ok = r_free_fnd || r_fin_fnd;
    assign pick      = r_free_fnd ? r_free_slot : r_fin_slot;
    assign ram_we    = i_cmd.finish && is_create && create_ok;

    always_comb begin
        n_used_cnt = r_used_cnt;
        n_pend_cnt = r_pend_cnt;
        if (ram_we) begin
            n_pend_cnt = r_pend_cnt + CW'(1);
            if (r_free_fnd) begin
                n_used_cnt = r_used_cnt + CW'(1);
            end
        end
    end

    assign o_stat.last_issue = (r_addr == SW'(SLOTS - 1));
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    ptt_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(pick),
        .i_wdata(new_word),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= CALL_CONTROL_RST;
            r_su <= SUPPLEMENTARY_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CALL_CONTROL) begin
                r_cc <= i_cfg_data;
            end else if (i_cfg_index == CFG_SUPPLEMENTARY) begin
                r_su <= i_cfg_data;
            end
        end
    end

    // Latch the word and run the scan pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_act   <= i_action;
            r_disc  <= i_disc;
            r_type  <= i_msg_type;
            r_ident <= i_trans_ident;
            r_timer <= i_timer_code;
            r_id    <= i_entry_id;
        end
        if (i_cmd.start) begin
            r_addr <= '0;
        end else if (i_cmd.issue && !o_stat.last_issue) begin
            r_addr <= r_addr + SW'(1);
        end
        r_chk_slot <= r_addr;
        if (hit_now) begin
            r_hit_slot <= r_chk_slot;
            r_hit_word <= rd;
        end
        if (r_chk_vld && is_create && !chk_used && !r_free_fnd) begin
            r_free_slot <= r_chk_slot;
        end
        if (r_chk_vld && is_create && chk_used && !chk_pend && !r_fin_fnd) begin
            r_fin_slot <= r_chk_slot;
            r_fin_word <= rd;
        end
    end

    // Scan control flags and the removed count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free_fnd <= 1'b0;
            r_fin_fnd  <= 1'b0;
            r_removed  <= '0;
        end else begin
            r_chk_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_hit      <= 1'b0;
                r_free_fnd <= 1'b0;
                r_fin_fnd  <= 1'b0;
                r_removed  <= '0;
            end else if (r_chk_vld) begin
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
                if (is_create && !chk_used) begin
                    r_free_fnd <= 1'b1;
                end
                if (is_create && chk_used && !chk_pend) begin
                    r_fin_fnd <= 1'b1;
                end
                if ((r_act == ACT_CLEANUP) && chk_used && !chk_pend) begin
                    r_removed <= r_removed + CW'(1);
                end
            end
        end
    end

    // Slot flags, index and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_used[i] <= 1'b0;
            end
            for (int j = 0; j < 8; j++) begin
                r_ix_vld[j] <= 1'b0;
            end
            r_used_cnt <= '0;
            r_pend_cnt <= '0;
        end else begin
            // clear the index before a rebuild
            if (i_cmd.start && (i_action == ACT_CLEANUP)) begin
                for (int j = 0; j < 8; j++) begin
                    r_ix_vld[j] <= 1'b0;
                end
            end
            if (r_chk_vld) begin
                // expire pending slots on this timer
                if ((r_act == ACT_EXPIRE) && chk_pend && (rd.timer == r_timer)) begin
                    r_life[r_chk_slot] <= LIFE_EXPIRED;
                    r_pend_cnt         <= r_pend_cnt - CW'(1);
                end
                // complete or cancel by id
                if (id_hit) begin
                    r_life[r_chk_slot] <= (r_act == ACT_COMPLETE) ? LIFE_COMPLETED
                                                                  : LIFE_CANCELLED;
                    r_pend_cnt         <= r_pend_cnt - CW'(1);
                end
                // free finished slots and rebuild the index
                if (r_act == ACT_CLEANUP) begin
                    if (chk_used && !chk_pend) begin
                        r_used[r_chk_slot] <= 1'b0;
                        if (r_used_cnt != '0) begin
                            r_used_cnt <= r_used_cnt - CW'(1);
                        end
                    end
                    if (chk_pend && keyed_rd && !rd.ident[3] && !r_ix_vld[rd.ident[2:0]]) begin
                        r_ix_vld[rd.ident[2:0]]  <= 1'b1;
                        r_ix_slot[rd.ident[2:0]] <= r_chk_slot;
                    end
                end
            end
            // commit a create
            if (ram_we) begin
                r_used[pick] <= 1'b1;
                r_life[pick] <= LIFE_PENDING;
                r_used_cnt   <= n_used_cnt;
                r_pend_cnt   <= n_pend_cnt;
                if (!r_free_fnd && keyed_fin && !r_fin_word.ident[3] &&
                    r_ix_vld[r_fin_word.ident[2:0]] &&
                    (r_ix_slot[r_fin_word.ident[2:0]] == r_fin_slot)) begin
                    r_ix_vld[r_fin_word.ident[2:0]] <= 1'b0;
                end
                if (keyed_req && !r_ident[3]) begin
                    r_ix_vld[r_ident[2:0]]  <= 1'b1;
                    r_ix_slot[r_ident[2:0]] <= pick;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_removed <= 5'(r_removed);
            r_out_pend    <= 5'(n_pend_cnt);
            r_out_used    <= 5'(n_used_cnt);
            if (is_create) begin
                r_found    <= create_ok;
                r_slot_id  <= create_ok ? 5'(IW'(pick) + IW'(1)) : 5'd0;
                r_out_word <= create_ok ? new_word : '0;
            end else begin
                r_found    <= r_hit;
                r_slot_id  <= r_hit ? 5'(IW'(r_hit_slot) + IW'(1)) : 5'd0;
                r_out_word <= r_hit ? r_hit_word : '0;
            end
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_slot_id        = r_slot_id;
    assign o_hit_disc       = r_out_word.disc;
    assign o_hit_type       = r_out_word.msg_type;
    assign o_hit_ident      = r_out_word.ident;
    assign o_hit_timer      = r_out_word.timer;
    assign o_removed        = r_out_removed;
    assign o_pending_total  = r_out_pend;
    assign o_occupied_total = r_out_used;

    // Count consistency and scan completion
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= r_used_cnt)
        else $error("pending count above occupied count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= CW'(SLOTS))
        else $error("occupied count above table size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_chk_vld)
        else $error("finish while a slot check is in flight");
endmodule

// ===== rtl/core/pending_transaction_table.sv =====
// The scan reads the slot RAM once per slot, then drains and registers the result.
// A new word is taken only in idle, after the previous scan has registered its result.
// A finished result may wait in the output register while the next word is taken.
// Reset (synchronous, active low) frees all slots, invalidates the index,
// zeroes the counts and loads the keyed codes 3 and 11. No clearing pass.
module pending_transaction_table #(
    parameter int SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_action,
    input  logic [3:0] i_disc,
    input  logic [7:0] i_msg_type,
    input  logic [3:0] i_trans_ident,
    input  logic [5:0] i_timer_code,
    input  logic [4:0] i_entry_id,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_found,
    output logic [4:0] o_slot_id,
    output logic [3:0] o_hit_disc,
    output logic [7:0] o_hit_type,
    output logic [3:0] o_hit_ident,
    output logic [5:0] o_hit_timer,
    output logic [4:0] o_removed,
    output logic [4:0] o_pending_total,
    output logic [4:0] o_occupied_total
);
    import ptt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    ptt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (stat),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd)
    );

    ptt_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_disc          (i_disc),
        .i_msg_type      (i_msg_type),
        .i_trans_ident   (i_trans_ident),
        .i_timer_code    (i_timer_code),
        .i_entry_id      (i_entry_id),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_found         (o_found),
        .o_slot_id       (o_slot_id),
        .o_hit_disc      (o_hit_disc),
        .o_hit_type      (o_hit_type),
        .o_hit_ident     (o_hit_ident),
        .o_hit_timer     (o_hit_timer),
        .o_removed       (o_removed),
        .o_pending_total (o_pending_total),
        .o_occupied_total(o_occupied_total)
    );
endmodule
